/* rtl/bmeter_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmeter_pkg
// Shared sizes, codes and helpers for the band meter with peak hold and decay.
// ----------------------------------------------------------------------------
package bmeter_pkg;

  localparam int BANDS      = 16;
  localparam int HIST_ROWS  = 32;
  localparam int BAND_W     = $clog2(BANDS);
  localparam int ROW_W      = $clog2(HIST_ROWS);
  localparam int CNT_W      = $clog2(BANDS + 1);
  localparam int HIST_DEPTH = BANDS * HIST_ROWS;

  // decay arithmetic: drop = (dt * rate) / DIV_CONST
  localparam int DT_W       = 10;
  localparam int PROD_W     = 2 * DT_W;
  localparam int DROP_W     = 11;
  localparam int DIV_CONST  = 1000;

  // divide by reciprocal multiply, exact for every product below 2**PROD_W
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + DIV_CONST - 1) / DIV_CONST;
  localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
  localparam int MUL_W       = PROD_W + RECIP_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HIST_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_RATE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELAPSED_CAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIVE_TIMEOUT = 3'd4;

  localparam logic [15:0] RST_HIST_PERIOD  = 16'd50;
  localparam logic [9:0]  RST_BAND_RATE    = 10'd360;
  localparam logic [9:0]  RST_PEAK_RATE    = 10'd85;
  localparam logic [9:0]  RST_ELAPSED_CAP  = 10'd200;
  localparam logic [15:0] RST_LIVE_TIMEOUT = 16'd2000;

  localparam logic [7:0]  MIN_MSG_LEN      = 8'd3;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BAND   = 2'd1,
    OP_TICK   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  function automatic logic [7:0] lower_by(input logic [7:0] v, input logic [DROP_W-1:0] by);
    lower_by = ({{(DROP_W-8){1'b0}}, v} > by) ? (v - by[7:0]) : 8'd0;
  endfunction

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add16 = s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/bmeter_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmeter_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmeter_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* rtl/band_meter_peak_hold_decay.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// band_meter_peak_hold_decay
// Spectrum meter: instant attack, timed release, peak hold, history ring.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done and its result is shown on the out_ ports with
// out_valid high for one cycle, starting at the edge where busy falls. The
// receiver cannot stall. A band or header item that completes a message and
// writes a history row copies one band per cycle into the history RAM. A tick
// uses one shared multiplier to form dt times rate and then scale it by a
// reciprocal of 1000, giving the band drop and then the peak drop, and the
// bands are then decayed one per cycle. History rows carry a valid bit each,
// so no clearing pass runs.
// ----------------------------------------------------------------------------
module band_meter_peak_hold_decay (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_message_length,
  input  wire logic [7:0]  in_level_in,
  input  wire logic [7:0]  in_peak_level_in,
  input  wire logic [7:0]  in_band_count,
  input  wire logic [7:0]  in_band_value,
  input  wire logic [15:0] in_elapsed_ms,
  input  wire logic [3:0]  in_read_band,
  input  wire logic [4:0]  in_read_row,

  output logic             out_valid,
  output logic [7:0]       out_level_out,
  output logic [7:0]       out_peak_level_out,
  output logic [7:0]       out_band_out,
  output logic [7:0]       out_peak_out,
  output logic [7:0]       out_history_out,
  output logic [4:0]       out_history_head_out,
  output logic             out_live,

  input  wire logic                               cfg_we,
  input  wire logic [bmeter_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmeter_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bmeter_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_COPY   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_OVR    = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  // configuration
  logic [15:0] hist_period_r;
  logic [9:0]  band_rate_r;
  logic [9:0]  peak_rate_r;
  logic [9:0]  elapsed_cap_r;
  logic [15:0] live_timeout_r;

  // latched item
  op_t         op_r;
  logic [7:0]  len_r;
  logic [7:0]  lv_r;
  logic [7:0]  pk_r;
  logic [7:0]  cnt_r;
  logic [7:0]  val_r;
  logic [15:0] el_r;
  logic [ROW_W-1:0] row_r;
  logic [BAND_W-1:0] rd_band_r;

  // state
  logic [3:0]  state_r, state_nxt;
  logic [7:0]  band_levels_r [BANDS];
  logic [7:0]  band_levels_nxt [BANDS];
  logic [7:0]  band_peaks_r [BANDS];
  logic [7:0]  band_peaks_nxt [BANDS];
  logic [7:0]  level_r, level_nxt;
  logic [7:0]  peak_r, peak_nxt;
  logic [ROW_W-1:0] head_r, head_nxt;
  logic [HIST_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] msg_ms_r, msg_ms_nxt;
  logic [15:0] hist_ms_r, hist_ms_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic        open_r, open_nxt;
  logic [BAND_W-1:0] idx_r, idx_nxt;

  // shared arithmetic
  logic [DT_W-1:0]   dt_r, dt_nxt;
  logic              sel_r, sel_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DROP_W-1:0] bdrop_r, bdrop_nxt;
  logic [DROP_W-1:0] pdrop_r, pdrop_nxt;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_level_r, out_level_nxt;
  logic [7:0]  out_peak_level_r, out_peak_level_nxt;
  logic [7:0]  out_band_r, out_band_nxt;
  logic [7:0]  out_peak_r, out_peak_nxt;
  logic [7:0]  out_hist_r, out_hist_nxt;
  logic [ROW_W-1:0] out_head_r, out_head_nxt;
  logic        out_live_r, out_live_nxt;

  logic        accept;
  logic [7:0]  cur_lvl;
  logic [7:0]  cur_pk;
  logic [CNT_W-1:0] n_clamp;
  logic [8:0]  hdr_need;
  logic [CNT_W-1:0] rcv_inc;
  logic [9:0]  mul_rate;
  logic [PROD_W-1:0] mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [MUL_W-1:0] mul_p;
  logic [DROP_W-1:0] mul_drop;
  logic [DT_W-1:0] dt_clamp;
  logic [7:0]  walk_lvl;
  logic [7:0]  walk_pk;
  logic [7:0]  ovr_lvl;
  logic [7:0]  ovr_pk;
  logic        do_complete;
  logic [ROW_W-1:0] head_inc;
  logic        hist_we;
  logic [7:0]  hist_rdata;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign cur_lvl  = band_levels_r[idx_r];
  assign cur_pk   = band_peaks_r[idx_r];
  assign n_clamp  = (cnt_r > 8'(BANDS)) ? CNT_W'(BANDS) : cnt_r[CNT_W-1:0];
  assign hdr_need = 9'(MIN_MSG_LEN) + 9'(n_clamp);
  assign rcv_inc  = rcv_r + 1'b1;
  assign head_inc = head_r + 1'b1;
  assign dt_clamp = (el_r > 16'(elapsed_cap_r)) ? elapsed_cap_r : el_r[DT_W-1:0];

  // S_MUL: dt * rate; S_DIV: product * reciprocal of DIV_CONST
  assign mul_rate = sel_r ? peak_rate_r : band_rate_r;
  assign mul_a    = (state_r == S_DIV) ? prod_r : PROD_W'(dt_r);
  assign mul_b    = (state_r == S_DIV) ? RECIP_W'(RECIP_MUL) : RECIP_W'(mul_rate);
  assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign mul_drop = mul_p[RECIP_SHIFT +: DROP_W];

  assign walk_lvl = lower_by(cur_lvl, bdrop_r);
  assign walk_pk  = (lower_by(cur_pk, pdrop_r) < walk_lvl) ? walk_lvl : lower_by(cur_pk, pdrop_r);
  assign ovr_lvl  = lower_by(level_r, bdrop_r);
  assign ovr_pk   = (lower_by(peak_r, pdrop_r) < ovr_lvl) ? ovr_lvl : lower_by(peak_r, pdrop_r);

  bmeter_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr ({head_r, idx_r}),
    .wdata (cur_lvl),
    .raddr ({row_r, rd_band_r}),
    .rdata (hist_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    band_levels_nxt = band_levels_r;
    band_peaks_nxt  = band_peaks_r;
    level_nxt       = level_r;
    peak_nxt        = peak_r;
    head_nxt        = head_r;
    row_valid_nxt   = row_valid_r;
    seen_nxt        = seen_r;
    msg_ms_nxt      = msg_ms_r;
    hist_ms_nxt     = hist_ms_r;
    exp_nxt         = exp_r;
    rcv_nxt         = rcv_r;
    open_nxt        = open_r;
    idx_nxt         = idx_r;
    dt_nxt          = dt_r;
    sel_nxt         = sel_r;
    prod_nxt        = prod_r;
    bdrop_nxt       = bdrop_r;
    pdrop_nxt       = pdrop_r;
    out_valid_nxt   = 1'b0;
    out_level_nxt      = out_level_r;
    out_peak_level_nxt = out_peak_level_r;
    out_band_nxt       = out_band_r;
    out_peak_nxt       = out_peak_r;
    out_hist_nxt       = out_hist_r;
    out_head_nxt       = out_head_r;
    out_live_nxt       = out_live_r;
    hist_we         = 1'b0;
    do_complete     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
          if (op_t'(in_operation) == OP_BAND) begin
            idx_nxt = rcv_r[BAND_W-1:0];
          end else begin
            idx_nxt = BAND_W'(in_read_band);
          end
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_HEADER: begin
            if (len_r >= MIN_MSG_LEN) begin
              level_nxt = lv_r;
              if (pk_r > peak_r) begin
                peak_nxt = pk_r;
              end
              if (hdr_need > 9'(len_r)) begin
                open_nxt = 1'b0;
              end else begin
                exp_nxt  = n_clamp;
                rcv_nxt  = '0;
                open_nxt = 1'b1;
                if (n_clamp == '0) begin
                  do_complete = 1'b1;
                end
              end
            end
          end
          OP_BAND: begin
            if (open_r && (rcv_r < exp_r)) begin
              if (val_r > cur_lvl) begin
                band_levels_nxt[idx_r] = val_r;
              end
              if (val_r > cur_pk) begin
                band_peaks_nxt[idx_r] = val_r;
              end
              rcv_nxt = rcv_inc;
              if (rcv_inc >= exp_r) begin
                do_complete = 1'b1;
              end
            end
          end
          OP_TICK: begin
            msg_ms_nxt  = sat_add16(msg_ms_r, el_r);
            hist_ms_nxt = sat_add16(hist_ms_r, el_r);
            dt_nxt      = dt_clamp;
            sel_nxt     = 1'b0;
            state_nxt   = S_MUL;
          end
          OP_READ: begin
          end
          default: begin
          end
        endcase
        if (do_complete) begin
          open_nxt   = 1'b0;
          seen_nxt   = 1'b1;
          msg_ms_nxt = '0;
          if (hist_ms_r >= hist_period_r) begin
            hist_ms_nxt             = '0;
            head_nxt                = head_inc;
            row_valid_nxt[head_inc] = 1'b1;
            idx_nxt                 = '0;
            state_nxt               = S_COPY;
          end
        end
      end
      S_COPY: begin
        hist_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == BAND_W'(BANDS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p[PROD_W-1:0];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sel_r) begin
          bdrop_nxt = mul_drop;
          sel_nxt   = 1'b1;
          state_nxt = S_MUL;
        end else begin
          pdrop_nxt = mul_drop;
          idx_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        band_levels_nxt[idx_r] = walk_lvl;
        band_peaks_nxt[idx_r]  = walk_pk;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == BAND_W'(BANDS - 1)) begin
          state_nxt = S_OVR;
        end
      end
      S_OVR: begin
        level_nxt = ovr_lvl;
        peak_nxt  = ovr_pk;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt      = 1'b1;
        out_level_nxt      = level_r;
        out_peak_level_nxt = peak_r;
        out_head_nxt       = head_r;
        out_live_nxt       = seen_r && (msg_ms_r < live_timeout_r);
        if (op_r == OP_READ) begin
          out_band_nxt = band_levels_r[rd_band_r];
          out_peak_nxt = band_peaks_r[rd_band_r];
          out_hist_nxt = row_valid_r[row_r] ? hist_rdata : 8'd0;
        end else begin
          out_band_nxt = 8'd0;
          out_peak_nxt = 8'd0;
          out_hist_nxt = 8'd0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      hist_period_r  <= RST_HIST_PERIOD;
      band_rate_r    <= RST_BAND_RATE;
      peak_rate_r    <= RST_PEAK_RATE;
      elapsed_cap_r  <= RST_ELAPSED_CAP;
      live_timeout_r <= RST_LIVE_TIMEOUT;
      for (int i = 0; i < BANDS; i++) begin
        band_levels_r[i] <= 8'd0;
        band_peaks_r[i]  <= 8'd0;
      end
      level_r     <= 8'd0;
      peak_r      <= 8'd0;
      head_r      <= '0;
      row_valid_r <= '0;
      seen_r      <= 1'b0;
      msg_ms_r    <= '0;
      hist_ms_r   <= '0;
      exp_r       <= '0;
      rcv_r       <= '0;
      open_r      <= 1'b0;
      idx_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      band_levels_r <= band_levels_nxt;
      band_peaks_r  <= band_peaks_nxt;
      level_r       <= level_nxt;
      peak_r        <= peak_nxt;
      head_r        <= head_nxt;
      row_valid_r   <= row_valid_nxt;
      seen_r        <= seen_nxt;
      msg_ms_r      <= msg_ms_nxt;
      hist_ms_r     <= hist_ms_nxt;
      exp_r         <= exp_nxt;
      rcv_r         <= rcv_nxt;
      open_r        <= open_nxt;
      idx_r         <= idx_nxt;
      sel_r         <= sel_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HIST_PERIOD:  hist_period_r  <= cfg_data;
          CFG_BAND_RATE:    band_rate_r    <= cfg_data[9:0];
          CFG_PEAK_RATE:    peak_rate_r    <= cfg_data[9:0];
          CFG_ELAPSED_CAP:  elapsed_cap_r  <= cfg_data[9:0];
          CFG_LIVE_TIMEOUT: live_timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op_t'(in_operation);
      len_r     <= in_message_length;
      lv_r      <= in_level_in;
      pk_r      <= in_peak_level_in;
      cnt_r     <= in_band_count;
      val_r     <= in_band_value;
      el_r      <= in_elapsed_ms;
      row_r     <= ROW_W'(in_read_row);
      rd_band_r <= BAND_W'(in_read_band);
    end
    dt_r             <= dt_nxt;
    prod_r           <= prod_nxt;
    bdrop_r          <= bdrop_nxt;
    pdrop_r          <= pdrop_nxt;
    out_level_r      <= out_level_nxt;
    out_peak_level_r <= out_peak_level_nxt;
    out_band_r       <= out_band_nxt;
    out_peak_r       <= out_peak_nxt;
    out_hist_r       <= out_hist_nxt;
    out_head_r       <= out_head_nxt;
    out_live_r       <= out_live_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_level_out        = out_level_r;
  assign out_peak_level_out   = out_peak_level_r;
  assign out_band_out         = out_band_r;
  assign out_peak_out         = out_peak_r;
  assign out_history_out      = out_hist_r;
  assign out_history_head_out = 5'(out_head_r);
  assign out_live             = out_live_r;

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DONE))
    else $error("result without finished item");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transfer did not start work");

  a_copy_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> row_valid_r[head_r])
    else $error("history write to row not marked valid");

  a_peak_holds_band: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (band_peaks_r[idx_r] >= band_levels_r[idx_r]))
    else $error("band peak below band level");

endmodule
`default_nettype wire
